### rtl/tsp_pkg.sv
// tsp_pkg: operation codes and the preset tone rom for the tone sequence player
// no dependencies
`timescale 1ns / 1ps

package tsp_pkg;

  typedef enum logic [1:0] {
    OP_TICK   = 2'd0,
    OP_PRESET = 2'd1,
    OP_BEEP   = 2'd2,
    OP_STOP   = 2'd3
  } tsp_op_t;

  localparam int unsigned PresetCount = 9;

  // step frequency in hz for flat rom address, outside the rom reads as silence
  function automatic logic [15:0] rom_freq(input logic [5:0] addr);
    logic [15:0] f;
    unique case (addr)
      6'd0:  f = 16'd2000;
      6'd1:  f = 16'd2000;
      6'd2:  f = 16'd0;
      6'd3:  f = 16'd2000;
      6'd4:  f = 16'd1500;
      6'd5:  f = 16'd0;
      6'd6:  f = 16'd1500;
      6'd7:  f = 16'd3000;
      6'd8:  f = 16'd0;
      6'd9:  f = 16'd3000;
      6'd10: f = 16'd0;
      6'd11: f = 16'd3000;
      6'd12: f = 16'd800;
      6'd13: f = 16'd0;
      6'd14: f = 16'd1200;
      6'd15: f = 16'd0;
      6'd16: f = 16'd800;
      6'd17: f = 16'd1000;
      6'd18: f = 16'd0;
      6'd19: f = 16'd800;
      6'd20: f = 16'd0;
      6'd21: f = 16'd600;
      6'd22: f = 16'd1800;
      6'd23: f = 16'd0;
      6'd24: f = 16'd2200;
      6'd25: f = 16'd1000;
      6'd26: f = 16'd0;
      6'd27: f = 16'd1000;
      6'd28: f = 16'd0;
      6'd29: f = 16'd1000;
      6'd30: f = 16'd1500;
      6'd31: f = 16'd0;
      6'd32: f = 16'd1000;
      default: f = 16'd0;
    endcase
    return f;
  endfunction

  // step duration in ms for flat rom address
  function automatic logic [15:0] rom_dur(input logic [5:0] addr);
    logic [15:0] d;
    unique case (addr)
      6'd0:  d = 16'd100;
      6'd1:  d = 16'd80;
      6'd2:  d = 16'd80;
      6'd3:  d = 16'd80;
      6'd4:  d = 16'd150;
      6'd5:  d = 16'd100;
      6'd6:  d = 16'd150;
      6'd7:  d = 16'd60;
      6'd8:  d = 16'd40;
      6'd9:  d = 16'd60;
      6'd10: d = 16'd40;
      6'd11: d = 16'd60;
      6'd12: d = 16'd300;
      6'd13: d = 16'd100;
      6'd14: d = 16'd150;
      6'd15: d = 16'd100;
      6'd16: d = 16'd300;
      6'd17: d = 16'd200;
      6'd18: d = 16'd50;
      6'd19: d = 16'd200;
      6'd20: d = 16'd50;
      6'd21: d = 16'd300;
      6'd22: d = 16'd60;
      6'd23: d = 16'd30;
      6'd24: d = 16'd80;
      6'd25: d = 16'd150;
      6'd26: d = 16'd80;
      6'd27: d = 16'd150;
      6'd28: d = 16'd80;
      6'd29: d = 16'd150;
      6'd30: d = 16'd100;
      6'd31: d = 16'd50;
      6'd32: d = 16'd150;
      default: d = 16'd0;
    endcase
    return d;
  endfunction

  // first rom address of each preset
  function automatic logic [5:0] preset_base(input logic [3:0] id);
    logic [5:0] b;
    unique case (id)
      4'd0: b = 6'd0;
      4'd1: b = 6'd1;
      4'd2: b = 6'd4;
      4'd3: b = 6'd7;
      4'd4: b = 6'd12;
      4'd5: b = 6'd17;
      4'd6: b = 6'd22;
      4'd7: b = 6'd25;
      4'd8: b = 6'd30;
      default: b = 6'd0;
    endcase
    return b;
  endfunction

  // number of steps of each preset
  function automatic logic [2:0] preset_len(input logic [3:0] id);
    logic [2:0] n;
    unique case (id)
      4'd0: n = 3'd1;
      4'd1: n = 3'd3;
      4'd2: n = 3'd3;
      4'd3: n = 3'd5;
      4'd4: n = 3'd5;
      4'd5: n = 3'd5;
      4'd6: n = 3'd3;
      4'd7: n = 3'd5;
      4'd8: n = 3'd3;
      default: n = 3'd0;
    endcase
    return n;
  endfunction

endpackage

### rtl/tone_sequence_player.sv
// tone_sequence_player: alert tone sequencer, one result per command or tick
// depends on tsp_pkg for operation codes and the preset rom
`timescale 1ns / 1ps

// Usage
//   slave channel: one transaction per command. s_tuser carries the operation
//   (tick of one millisecond, play preset, custom beep, stop), s_tdata carries
//   the preset number and the custom beep frequency and duration.
//   master channel: one transaction per accepted command, giving the buzzer
//   state after the command: tone on, tone frequency in hz, busy.
// Latency: the result is on m_tdata the cycle after the command is accepted.
// Throughput: one command per cycle while m_tready keeps up; the step lookup,
//   elapsed compare and advance all sit between the playback state registers
//   and the output register, so back to back commands run at full rate.
// Stall: while a result waits on a low m_tready, the output register holds it
//   and s_tready drops; a result taken in the same cycle frees the slot.
// Reset: playback stops, all state clears to silence, no result pending.
module tone_sequence_player
  import tsp_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,   // preset_id[3:0], beep_freq[19:4], beep_duration_ms[35:20]
  input  logic [1:0]  s_tuser,   // op[1:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata    // tone_on[0], tone_freq[16:1], busy_res[17]
);

  logic        playing_flag, playing_flag_next;
  logic        custom_mode, custom_mode_next;
  logic [5:0]  sequence_base, sequence_base_next;
  logic [2:0]  sequence_length, sequence_length_next;
  logic [2:0]  step_index, step_index_next;
  logic [15:0] elapsed_ms, elapsed_ms_next;
  logic [15:0] custom_step_freq, custom_step_freq_next;
  logic [15:0] custom_step_duration, custom_step_duration_next;
  logic [15:0] current_freq, current_freq_next;

  logic        s_accept;
  tsp_op_t     op;
  logic [3:0]  preset_id;
  logic [15:0] beep_freq;
  logic [15:0] beep_duration_ms;

  logic [2:0]  step_inc;
  logic [5:0]  addr_cur;
  logic [5:0]  addr_inc;
  logic [15:0] cur_dur;
  logic [15:0] inc_freq;
  logic [15:0] elapsed_sat;
  logic        tone_on_next;

  assign s_tready         = !m_tvalid || m_tready;
  assign s_accept         = s_tvalid && s_tready;
  assign op               = tsp_op_t'(s_tuser);
  assign preset_id        = s_tdata[3:0];
  assign beep_freq        = s_tdata[19:4];
  assign beep_duration_ms = s_tdata[35:20];

  // both rom addresses in parallel: current step and the one after it
  assign step_inc    = step_index + 3'd1;
  assign addr_cur    = sequence_base + {3'd0, step_index};
  assign addr_inc    = sequence_base + {3'd0, step_inc};
  assign cur_dur     = custom_mode ? custom_step_duration : rom_dur(addr_cur);
  assign inc_freq    = custom_mode ? custom_step_freq : rom_freq(addr_inc);
  assign elapsed_sat = (elapsed_ms == 16'hFFFF) ? elapsed_ms : elapsed_ms + 16'd1;

  always_comb begin
    playing_flag_next         = playing_flag;
    custom_mode_next          = custom_mode;
    sequence_base_next        = sequence_base;
    sequence_length_next      = sequence_length;
    step_index_next           = step_index;
    elapsed_ms_next           = elapsed_ms;
    custom_step_freq_next     = custom_step_freq;
    custom_step_duration_next = custom_step_duration;
    current_freq_next         = current_freq;
    unique case (op)
      OP_TICK: begin
        if (playing_flag) begin
          elapsed_ms_next = elapsed_sat;
          if (elapsed_sat >= cur_dur) begin
            step_index_next = step_inc;
            if (step_inc >= sequence_length) begin
              playing_flag_next = 1'b0;
              current_freq_next = '0;
            end else begin
              elapsed_ms_next   = '0;
              current_freq_next = inc_freq;
            end
          end
        end
      end
      OP_PRESET: begin
        if (preset_id < 4'(PresetCount)) begin
          custom_mode_next     = 1'b0;
          sequence_base_next   = preset_base(preset_id);
          sequence_length_next = preset_len(preset_id);
          step_index_next      = '0;
          elapsed_ms_next      = '0;
          playing_flag_next    = 1'b1;
          current_freq_next    = rom_freq(preset_base(preset_id));
        end
      end
      OP_BEEP: begin
        custom_mode_next          = 1'b1;
        custom_step_freq_next     = beep_freq;
        custom_step_duration_next = beep_duration_ms;
        sequence_length_next      = 3'd1;
        step_index_next           = '0;
        elapsed_ms_next           = '0;
        playing_flag_next         = 1'b1;
        current_freq_next         = beep_freq;
      end
      OP_STOP: begin
        playing_flag_next = 1'b0;
        current_freq_next = '0;
      end
      default: begin
        playing_flag_next = playing_flag;
      end
    endcase
  end

  assign tone_on_next = playing_flag_next && (current_freq_next != 16'd0);

  always_ff @(posedge clk) begin
    if (rst) begin
      playing_flag         <= 1'b0;
      custom_mode          <= 1'b0;
      sequence_base        <= '0;
      sequence_length      <= '0;
      step_index           <= '0;
      elapsed_ms           <= '0;
      custom_step_freq     <= '0;
      custom_step_duration <= '0;
      current_freq         <= '0;
    end else if (s_accept) begin
      playing_flag         <= playing_flag_next;
      custom_mode          <= custom_mode_next;
      sequence_base        <= sequence_base_next;
      sequence_length      <= sequence_length_next;
      step_index           <= step_index_next;
      elapsed_ms           <= elapsed_ms_next;
      custom_step_freq     <= custom_step_freq_next;
      custom_step_duration <= custom_step_duration_next;
      current_freq         <= current_freq_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (s_accept) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_accept) begin
      m_tdata <= {6'd0, playing_flag_next,
                  tone_on_next ? current_freq_next : 16'd0, tone_on_next};
    end
  end

  // silence whenever nothing plays
  a_idle_silent: assert property (@(posedge clk) disable iff (rst)
    !playing_flag |-> current_freq == 16'd0)
    else $error("frequency held while idle");

  // a playing step always lies inside its sequence
  a_step_in_range: assert property (@(posedge clk) disable iff (rst)
    playing_flag |-> step_index < sequence_length)
    else $error("step index past sequence end");

  // a stop transaction always ends playback
  a_stop_halts: assert property (@(posedge clk) disable iff (rst)
    s_accept && op == OP_STOP |=> !playing_flag && m_tdata[17] == 1'b0)
    else $error("stop did not halt playback");

  // the tone can only be on while busy
  a_tone_busy: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[0] |-> m_tdata[17] && m_tdata[16:1] != 16'd0)
    else $error("tone on without playback");

endmodule
